// ----- src/tosf_pkg.sv -----
`default_nettype none

package tosf_pkg;

   localparam int unsigned STEP_W = 5;

   localparam logic [15:0] COEF_SPEED = 16'd5489;
   localparam logic [15:0] COEF_ACCEL = 16'd14828;
   localparam logic [15:0] COEF_JERK  = 16'd40018;

   localparam logic [23:0] RATE_GAIN_RESET = 24'd45416;
   localparam logic [23:0] TIME_STEP_RESET = 24'd16777;

   typedef enum logic {
      CSR_RATE_GAIN = 1'b0,
      CSR_TIME_STEP = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_JMP_KIND,
      SEQ_JMP,
      SEQ_END
   } seq_op_type;

   typedef enum logic [2:0] {
      MA_COEF,
      MA_DIFF,
      MA_SAT,
      MA_ACC,
      MA_SPD
   } mul_a_sel_type;

   typedef enum logic [1:0] {
      MB_GAIN,
      MB_GLO,
      MB_GHI,
      MB_STEP
   } mul_b_sel_type;

   typedef enum logic [1:0] {
      CF_SPEED,
      CF_ACCEL,
      CF_JERK
   } coef_sel_type;

   typedef enum logic [1:0] {
      AC_NONE,
      AC_LOAD,
      AC_ADD
   } accum_op_type;

   typedef enum logic [1:0] {
      DF_NONE,
      DF_TARGET,
      DF_SPEED,
      DF_ACCEL
   } diff_op_type;

   typedef enum logic [2:0] {
      ST_NONE,
      ST_ACCEL,
      ST_SPEED,
      ST_VALUE,
      ST_LOAD
   } state_op_type;

   typedef struct packed {
      seq_op_type          seq_op;
      logic [STEP_W-1:0]   jump_to;
      logic                mul_en;
      mul_a_sel_type       mul_a;
      mul_b_sel_type       mul_b;
      coef_sel_type        coef;
      logic                gain_load;
      accum_op_type        accum_op;
      diff_op_type         diff_op;
      state_op_type        state_op;
   } ctrl_type;

   localparam logic [STEP_W-1:0] STEP_DONE  = 5'd19;
   localparam logic [STEP_W-1:0] STEP_RESET = 5'd20;

   localparam ctrl_type CTRL_NOP = '{
      seq_op:    SEQ_NEXT,
      jump_to:   '0,
      mul_en:    1'b0,
      mul_a:     MA_COEF,
      mul_b:     MB_GAIN,
      coef:      CF_SPEED,
      gain_load: 1'b0,
      accum_op:  AC_NONE,
      diff_op:   DF_NONE,
      state_op:  ST_NONE
   };

   function automatic ctrl_type ucode(input logic [STEP_W-1:0] step);
      ctrl_type w;
      w = CTRL_NOP;
      unique case (step)
         5'd0: begin
            w.seq_op  = SEQ_JMP_KIND;
            w.jump_to = STEP_RESET;
            w.mul_en  = 1'b1;
            w.mul_a   = MA_COEF;
            w.mul_b   = MB_GAIN;
            w.coef    = CF_SPEED;
            w.diff_op = DF_TARGET;
         end
         5'd1: begin
            w.gain_load = 1'b1;
         end
         5'd2: begin
            w.mul_en = 1'b1;
            w.mul_a  = MA_DIFF;
            w.mul_b  = MB_GLO;
         end
         5'd3: begin
            w.accum_op = AC_LOAD;
            w.mul_en   = 1'b1;
            w.mul_a    = MA_DIFF;
            w.mul_b    = MB_GHI;
         end
         5'd4: begin
            w.accum_op = AC_ADD;
            w.mul_en   = 1'b1;
            w.mul_a    = MA_COEF;
            w.mul_b    = MB_GAIN;
            w.coef     = CF_ACCEL;
         end
         5'd5: begin
            w.gain_load = 1'b1;
            w.diff_op   = DF_SPEED;
         end
         5'd6: begin
            w.mul_en = 1'b1;
            w.mul_a  = MA_DIFF;
            w.mul_b  = MB_GLO;
         end
         5'd7: begin
            w.accum_op = AC_LOAD;
            w.mul_en   = 1'b1;
            w.mul_a    = MA_DIFF;
            w.mul_b    = MB_GHI;
         end
         5'd8: begin
            w.accum_op = AC_ADD;
            w.mul_en   = 1'b1;
            w.mul_a    = MA_COEF;
            w.mul_b    = MB_GAIN;
            w.coef     = CF_JERK;
         end
         5'd9: begin
            w.gain_load = 1'b1;
            w.diff_op   = DF_ACCEL;
         end
         5'd10: begin
            w.mul_en = 1'b1;
            w.mul_a  = MA_DIFF;
            w.mul_b  = MB_GLO;
         end
         5'd11: begin
            w.accum_op = AC_LOAD;
            w.mul_en   = 1'b1;
            w.mul_a    = MA_DIFF;
            w.mul_b    = MB_GHI;
         end
         5'd12: begin
            w.accum_op = AC_ADD;
         end
         5'd13: begin
            w.mul_en = 1'b1;
            w.mul_a  = MA_SAT;
            w.mul_b  = MB_STEP;
         end
         5'd14: begin
            w.state_op = ST_ACCEL;
         end
         5'd15: begin
            w.mul_en = 1'b1;
            w.mul_a  = MA_ACC;
            w.mul_b  = MB_STEP;
         end
         5'd16: begin
            w.state_op = ST_SPEED;
         end
         5'd17: begin
            w.mul_en = 1'b1;
            w.mul_a  = MA_SPD;
            w.mul_b  = MB_STEP;
         end
         5'd18: begin
            w.state_op = ST_VALUE;
         end
         5'd19: begin
            w.seq_op = SEQ_END;
         end
         5'd20: begin
            w.state_op = ST_LOAD;
            w.seq_op   = SEQ_JMP;
            w.jump_to  = STEP_DONE;
         end
         default: begin
            w.seq_op  = SEQ_JMP;
            w.jump_to = STEP_DONE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- src/third_order_smoothing_filter.sv -----
`default_nettype none

// Third-order tracking smoother in Q16.16. Each request word carries a kind flag in tuser:
// an update (0) chases target through three chained integrators, a reset (1) loads value
// and speed and clears accel. Every request gives exactly one response word with the
// value, speed and accel states after it. A small microprogram steps one shared
// 33 x 25 bit multiplier through the gains, the three scaled errors (each gain product
// split into two halves) and the three integrations. One request is in work at a time;
// the next is accepted as soon as the sequencer has handed its result to the response
// register, even while that response still waits to be taken.
module third_order_smoothing_filter (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // target [31:0], init_speed [63:32]
   input  wire logic         req_tuser,   // kind
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [95:0]       rsp_tdata,   // filtered_value, filtered_speed, filtered_accel
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [23:0]  csr_wdata
);

   localparam int unsigned SW = tosf_pkg::STEP_W;

   tosf_pkg::ctrl_type ctrl;

   logic              busy_ff, busy_in;
   logic [SW-1:0]     step_ff, step_in;
   logic              kind_ff;
   logic signed [31:0] target_ff, init_ff;
   logic [23:0]       rate_gain_ff, time_step_ff;

   logic signed [31:0] value_ff, value_in;
   logic signed [31:0] speed_ff, speed_in;
   logic signed [31:0] accel_ff, accel_in;

   logic [27:0]       gain_ff;
   logic signed [32:0] diff_ff, diff_in;
   logic signed [57:0] prod_ff;
   logic signed [61:0] accum_ff, accum_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [95:0]       rsp_data_ff;

   logic signed [32:0] mul_a;
   logic signed [24:0] mul_b;
   logic [15:0]       coef;
   logic signed [45:0] accum_shr;
   logic signed [31:0] sat_out;
   logic signed [31:0] integ_base;
   logic signed [34:0] integ_sum;
   logic signed [31:0] integ_out;
   logic              accept;
   logic              end_go;

   function automatic logic signed [31:0] sat46(input logic signed [45:0] x);
      if (x > 46'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (x < -46'sd2147483648) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

   function automatic logic signed [31:0] sat35(input logic signed [34:0] x);
      if (x > 35'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (x < -35'sd2147483648) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

   assign ctrl       = tosf_pkg::ucode(step_ff);
   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && !busy_ff;
   assign end_go     = busy_ff && (ctrl.seq_op == tosf_pkg::SEQ_END)
                       && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // datapath operand selection
   always_comb begin
      unique case (ctrl.coef)
         tosf_pkg::CF_SPEED: coef = tosf_pkg::COEF_SPEED;
         tosf_pkg::CF_ACCEL: coef = tosf_pkg::COEF_ACCEL;
         tosf_pkg::CF_JERK:  coef = tosf_pkg::COEF_JERK;
         default:            coef = tosf_pkg::COEF_SPEED;
      endcase
   end

   assign accum_shr = accum_ff[61:16];
   assign sat_out   = sat46(accum_shr);

   always_comb begin
      unique case (ctrl.mul_a)
         tosf_pkg::MA_COEF: mul_a = {17'd0, coef};
         tosf_pkg::MA_DIFF: mul_a = diff_ff;
         tosf_pkg::MA_SAT:  mul_a = {sat_out[31], sat_out};
         tosf_pkg::MA_ACC:  mul_a = {accel_ff[31], accel_ff};
         tosf_pkg::MA_SPD:  mul_a = {speed_ff[31], speed_ff};
         default:           mul_a = diff_ff;
      endcase
      unique case (ctrl.mul_b)
         tosf_pkg::MB_GAIN: mul_b = {1'b0, rate_gain_ff};
         tosf_pkg::MB_GLO:  mul_b = {11'd0, gain_ff[13:0]};
         tosf_pkg::MB_GHI:  mul_b = {11'd0, gain_ff[27:14]};
         tosf_pkg::MB_STEP: mul_b = {1'b0, time_step_ff};
         default:           mul_b = {1'b0, time_step_ff};
      endcase
   end

   // integration: state + (dt * rate) >> 24, rate product already in prod_ff
   always_comb begin
      unique case (ctrl.state_op)
         tosf_pkg::ST_SPEED: integ_base = speed_ff;
         tosf_pkg::ST_VALUE: integ_base = value_ff;
         default:            integ_base = accel_ff;
      endcase
      integ_sum = 35'(integ_base) + 35'($signed(prod_ff[57:24]));
      integ_out = sat35(integ_sum);
   end

   always_comb begin
      value_in = value_ff;
      speed_in = speed_ff;
      accel_in = accel_ff;
      unique case (ctrl.state_op)
         tosf_pkg::ST_ACCEL: accel_in = integ_out;
         tosf_pkg::ST_SPEED: speed_in = integ_out;
         tosf_pkg::ST_VALUE: value_in = integ_out;
         tosf_pkg::ST_LOAD: begin
            value_in = target_ff;
            speed_in = init_ff;
            accel_in = '0;
         end
         default: begin
         end
      endcase

      unique case (ctrl.diff_op)
         tosf_pkg::DF_TARGET: diff_in = 33'(target_ff) - 33'(value_ff);
         tosf_pkg::DF_SPEED:  diff_in = 33'(sat_out) - 33'(speed_ff);
         tosf_pkg::DF_ACCEL:  diff_in = 33'(sat_out) - 33'(accel_ff);
         default:             diff_in = diff_ff;
      endcase

      unique case (ctrl.accum_op)
         tosf_pkg::AC_LOAD: accum_in = 62'(prod_ff);
         tosf_pkg::AC_ADD:  accum_in = accum_ff + {prod_ff[47:0], 14'd0};
         default:           accum_in = accum_ff;
      endcase
   end

   // sequencer
   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         unique case (ctrl.seq_op)
            tosf_pkg::SEQ_NEXT:     step_in = step_ff + 1'b1;
            tosf_pkg::SEQ_JMP_KIND: step_in = kind_ff ? ctrl.jump_to : step_ff + 1'b1;
            tosf_pkg::SEQ_JMP:      step_in = ctrl.jump_to;
            tosf_pkg::SEQ_END: begin
               if (end_go) begin
                  busy_in      = 1'b0;
                  rsp_valid_in = 1'b1;
               end
            end
            default: step_in = tosf_pkg::STEP_DONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rate_gain_ff <= tosf_pkg::RATE_GAIN_RESET;
         time_step_ff <= tosf_pkg::TIME_STEP_RESET;
         value_ff     <= '0;
         speed_ff     <= '0;
         accel_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               tosf_pkg::CSR_RATE_GAIN: rate_gain_ff <= csr_wdata;
               tosf_pkg::CSR_TIME_STEP: time_step_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (busy_ff) begin
            value_ff <= value_in;
            speed_ff <= speed_in;
            accel_ff <= accel_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_tuser;
         target_ff <= req_tdata[31:0];
         init_ff   <= req_tdata[63:32];
      end
      if (busy_ff) begin
         diff_ff  <= diff_in;
         accum_ff <= accum_in;
         if (ctrl.mul_en) begin
            prod_ff <= 58'(mul_a * mul_b);
         end
         if (ctrl.gain_load) begin
            gain_ff <= prod_ff[39:12];
         end
      end
      if (end_go) begin
         rsp_data_ff <= {accel_ff, speed_ff, value_ff};
      end
   end

endmodule

`default_nettype wire
